// ===== rtl/byte_level_utf8_to_raw_bytes_defines.svh =====
// Assertion macros for the byte-level UTF-8 to raw byte decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BYTE_LEVEL_UTF8_TO_RAW_BYTES_DEFINES_SVH
`define BYTE_LEVEL_UTF8_TO_RAW_BYTES_DEFINES_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define BLU2B_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// same-cycle implication
`define BLU2B_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BLU2B_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BLU2B_ASSERT(lbl, clk, rst, expr)
`define BLU2B_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BLU2B_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/blu2b_pkg.sv =====
// Package for the byte-level UTF-8 to raw byte decoder: types, constants,
// lead-byte length, code point assembly and the reverse byte table. No dependencies.
`timescale 1ns / 1ps

package blu2b_pkg;

  typedef logic [20:0] cp_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } map_t;

  // lead byte classes
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;

  // reverse byte table ranges
  localparam cp_t CP_PRINT_LO = 21'd33;
  localparam cp_t CP_PRINT_HI = 21'd126;
  localparam cp_t CP_LAT_LO   = 21'd161;
  localparam cp_t CP_LAT_HI   = 21'd172;
  localparam cp_t CP_SHY      = 21'd173;
  localparam cp_t CP_BYTE_HI  = 21'd255;
  localparam cp_t CP_SHIFT_LO = 21'd256;
  localparam cp_t CP_SHIFT_HI = 21'd323;

  localparam logic [8:0] OFF_BASE   = 9'd256;
  localparam logic [8:0] OFF_CTRL   = 9'd32;
  localparam logic [8:0] OFF_HIGH   = 9'd66;
  localparam logic [7:0] HIGH_ADJ   = 8'd94;
  localparam logic [7:0] BYTE_SHY   = 8'd173;

  // sequence length announced by a lead byte (1 for anything else)
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7])                          len = 3'd1;
    else if ((b & MASK_LEAD2) == CODE_LEAD2) len = 3'd2;
    else if ((b & MASK_LEAD3) == CODE_LEAD3) len = 3'd3;
    else if ((b & MASK_LEAD4) == CODE_LEAD4) len = 3'd4;
    else                                len = 3'd1;
    return len;
  endfunction

  // assemble a code point; continuation bytes contribute their low six bits
  function automatic cp_t decode_cp(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic [2:0] len);
    cp_t cp;
    case (len)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  // reverse byte table: identity ranges, shifted block 256..323, else dropped
  function automatic map_t map_cp(input cp_t cp);
    map_t       r;
    logic [8:0] off;
    r.ok  = 1'b0;
    r.val = 8'd0;
    off   = cp[8:0] - OFF_BASE;
    if ((cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) ||
        (cp >= CP_LAT_LO && cp <= CP_LAT_HI) ||
        (cp > CP_SHY && cp <= CP_BYTE_HI)) begin
      r.ok  = 1'b1;
      r.val = cp[7:0];
    end else if (cp >= CP_SHIFT_LO && cp <= CP_SHIFT_HI) begin
      r.ok = 1'b1;
      if (off <= OFF_CTRL)      r.val = off[7:0];
      else if (off <= OFF_HIGH) r.val = off[7:0] + HIGH_ADJ;
      else                      r.val = BYTE_SHY;
    end
    return r;
  endfunction

endpackage

// ===== rtl/byte_level_utf8_to_raw_bytes.sv =====
// Top level of the byte-level UTF-8 to raw byte decoder.
// Depends on blu2b_pkg and byte_level_utf8_to_raw_bytes_defines.svh.
`timescale 1ns / 1ps
`include "byte_level_utf8_to_raw_bytes_defines.svh"

//  channel | dir | tdata        | tlast     | tuser
//  --------+-----+--------------+-----------+------------------------------
//  s_*     | in  | [7:0] in_byte| text_last | -
//  m_*     | out | [7:0] out_byte| run_last | [0] byte_valid, [1] text_end
//
//  One input byte is taken per cycle while s_tready is high; its results
//  appear in the cycle after the decoder takes it. A sequence that is still
//  open consumes the byte with no beat out. The final byte of a text can emit
//  up to three beats, one per cycle while m_tready is high, held in the
//  three-entry result buffer. A byte that arrives while a group drains or a
//  beat waits on m_tready parks in the skid register, and s_tready stays low
//  until the decoder takes it. rst is synchronous and clears all valid flags.

module byte_level_utf8_to_raw_bytes (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // text_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic [1:0] m_tuser    // [0] byte_valid, [1] text_end
);

  // input skid register
  logic       skid_valid;
  logic [7:0] skid_byte;
  logic       skid_last;

  // sequence state
  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [2:0] sequence_length;

  // result buffer, slot 0 is the beat on the bus
  logic [7:0] res_byte [3];
  logic [1:0] res_cnt;
  logic       res_bv;
  logic       res_end;

  logic       s_fire, m_fire, proc_ready, proc_fire;
  logic       src_valid, src_last;
  logic [7:0] src_byte;
  logic [2:0] n_bytes, len_cur;
  logic       hold, complete, pair;
  logic [7:0] buf0, buf1, buf2;
  blu2b_pkg::cp_t  cp_a, cp_b, cp_c;
  blu2b_pkg::map_t map_a, map_b, map_c;
  logic [2:0] cand_v;
  logic [7:0] cand_b [3];
  logic [7:0] slot_b [3];
  logic [1:0] cnt_next;
  logic       bv_next;

  // handshakes
  assign s_tready   = !skid_valid && !rst;
  assign s_fire     = s_tvalid && s_tready;
  assign m_fire     = m_tvalid && m_tready;
  assign proc_ready = (res_cnt == 2'd0) || (res_cnt == 2'd1 && m_tready);

  assign src_valid  = skid_valid || s_fire;
  assign src_byte   = skid_valid ? skid_byte : s_tdata;
  assign src_last   = skid_valid ? skid_last : s_tlast;
  assign proc_fire  = src_valid && proc_ready;

  // skid register: catches a beat the decoder cannot take this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid && s_fire && !proc_ready) begin
      skid_valid <= 1'b1;
    end else if (skid_valid && proc_ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && !skid_valid) begin
      skid_byte <= s_tdata;
      skid_last <= s_tlast;
    end
  end

  // assemble the working buffer: held bytes followed by the new byte
  assign buf0    = (held_count == 2'd0) ? src_byte : held_bytes[0];
  assign buf1    = (held_count == 2'd1) ? src_byte : held_bytes[1];
  assign buf2    = (held_count == 2'd2) ? src_byte : held_bytes[2];
  assign n_bytes = {1'b0, held_count} + 3'd1;
  assign len_cur = (held_count != 2'd0) ? sequence_length
                                        : blu2b_pkg::lead_len(src_byte);
  assign complete = n_bytes >= len_cur;
  assign hold     = !src_last && !complete;

  // first code point: whole sequence, or the lead byte alone on a cut-off end
  assign cp_a = complete ? blu2b_pkg::decode_cp(buf0, buf1, buf2, src_byte, len_cur)
                         : {13'd0, buf0};
  // bytes after a cut-off lead are parsed again; only a two-byte pair can fit
  assign pair = (held_count == 2'd2) && (blu2b_pkg::lead_len(buf1) == 3'd2);
  assign cp_b = pair ? blu2b_pkg::decode_cp(buf1, buf2, 8'd0, 8'd0, 3'd2)
                     : {13'd0, buf1};
  assign cp_c = {13'd0, buf2};

  assign map_a = blu2b_pkg::map_cp(cp_a);
  assign map_b = blu2b_pkg::map_cp(cp_b);
  assign map_c = blu2b_pkg::map_cp(cp_c);

  assign cand_v[0] = map_a.ok;
  assign cand_v[1] = !complete && (held_count != 2'd0) && map_b.ok;
  assign cand_v[2] = !complete && (held_count == 2'd2) && !pair && map_c.ok;
  assign cand_b[0] = map_a.val;
  assign cand_b[1] = map_b.val;
  assign cand_b[2] = map_c.val;

  // pack surviving bytes into the result slots in order
  always_comb begin
    logic [1:0] cnt;
    cnt     = 2'd0;
    bv_next = 1'b1;
    for (int i = 0; i < 3; i++) begin
      slot_b[i] = 8'd0;
    end
    for (int i = 0; i < 3; i++) begin
      if (cand_v[i]) begin
        slot_b[cnt] = cand_b[i];
        cnt         = cnt + 2'd1;
      end
    end
    if (hold) begin
      cnt_next = 2'd0;
    end else if (cnt == 2'd0 && src_last) begin
      // end of text with nothing decoded: a lone marker beat
      cnt_next  = 2'd1;
      slot_b[0] = 8'd0;
      bv_next   = 1'b0;
    end else begin
      cnt_next = cnt;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      sequence_length <= 3'd0;
    end else if (proc_fire) begin
      if (hold) begin
        held_count      <= n_bytes[1:0];
        sequence_length <= len_cur;
      end else begin
        held_count      <= 2'd0;
        sequence_length <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && hold) begin
      held_bytes[held_count] <= src_byte;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (proc_fire) begin
      res_cnt <= cnt_next;
    end else if (m_fire) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  // result buffer payload: load a new group or shift one beat out
  always_ff @(posedge clk) begin
    if (proc_fire) begin
      res_byte[0] <= slot_b[0];
      res_byte[1] <= slot_b[1];
      res_byte[2] <= slot_b[2];
      res_bv      <= bv_next;
      res_end     <= src_last;
    end else if (m_fire) begin
      res_byte[0] <= res_byte[1];
      res_byte[1] <= res_byte[2];
    end
  end

  // output beat
  assign m_tvalid   = res_cnt != 2'd0;
  assign m_tdata    = res_byte[0];
  assign m_tlast    = res_cnt == 2'd1;
  assign m_tuser[0] = res_bv;
  assign m_tuser[1] = res_end && (res_cnt == 2'd1);

  // checks
  `BLU2B_ASSERT_IMP(a_held_short, clk, rst, held_count != 2'd0,
                    sequence_length > 3'(held_count))
  `BLU2B_ASSERT_IMP(a_marker_alone, clk, rst, m_tvalid && !m_tuser[0],
                    m_tlast && m_tuser[1] && m_tdata == 8'd0)
  `BLU2B_ASSERT_NXT(a_end_clears, clk, rst, proc_fire && src_last,
                    held_count == 2'd0 && sequence_length == 3'd0)

endmodule
